@@ hw/rtl/polyline_length_accumulator_unit_assert.svh @@
// ----------------------------------------------------------------------------
// polyline length accumulator assertion macros
// shared property forms for the checker, clocked and reset-gated
// ----------------------------------------------------------------------------
`ifndef POLYLINE_LENGTH_ACCUMULATOR_UNIT_ASSERT_SVH
`define POLYLINE_LENGTH_ACCUMULATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define PLA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pla check failed");

// next-cycle implication
`define PLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pla check failed");

`endif

@@ hw/rtl/pla_pkg.sv @@
// ----------------------------------------------------------------------------
// pla_pkg
// types and constants shared by the polyline length accumulator
// ----------------------------------------------------------------------------
package pla_pkg;

    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 8;
    localparam int CHAIN_BITS = 40;
    localparam int TOTAL_BITS = 48;

    // sum of two squares and the bit-serial root over it
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int RAD_BITS   = SQ_BITS + 1;
    localparam int ROOT_STEPS = (RAD_BITS + 1) / 2;
    localparam int RAD_PAD    = 2 * ROOT_STEPS;
    localparam int ROOT_BITS  = ROOT_STEPS;
    localparam int REM_BITS   = ROOT_BITS + 2;
    localparam int STEP_BITS  = $clog2(ROOT_STEPS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         chain_start;
        logic                         chain_end;
        logic                         total_clear;
    } point_t;

    typedef struct packed {
        logic [CHAIN_BITS-1:0] chain_length;
        logic [TOTAL_BITS-1:0] total_length;
        logic                  saturated;
    } result_t;

    // classified work handed from front to back
    typedef struct packed {
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        logic                  add_dist;
        logic                  restart;
        logic                  chain_end;
        logic                  total_clear;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_ROOT,
        ST_CHAIN,
        ST_CLOSE
    } back_state_t;

endpackage

@@ hw/rtl/pla_front.sv @@
// ----------------------------------------------------------------------------
// pla_front
// takes points, tracks the previous point and classifies each request
// ----------------------------------------------------------------------------
module pla_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            point_valid,
    output logic            point_stall,
    input  pla_pkg::point_t point,
    input  logic            job_full,
    output logic            job_push,
    output pla_pkg::job_t   job
);

    logic [pla_pkg::COORD_BITS-1:0] prev_x_reg, prev_x_next;
    logic [pla_pkg::COORD_BITS-1:0] prev_y_reg, prev_y_next;
    logic                           have_prev_reg, have_prev_next;
    logic signed [pla_pkg::COORD_BITS:0] diff_x, diff_y;
    logic [pla_pkg::COORD_BITS:0]        mag_x, mag_y;
    logic restart;

    assign point_stall = job_full;
    assign job_push    = point_valid && !job_full;

    always_comb
    begin
        diff_x = {point.point_x[pla_pkg::COORD_BITS-1], point.point_x}
               - {prev_x_reg[pla_pkg::COORD_BITS-1], prev_x_reg};
        diff_y = {point.point_y[pla_pkg::COORD_BITS-1], point.point_y}
               - {prev_y_reg[pla_pkg::COORD_BITS-1], prev_y_reg};
        mag_x = diff_x[pla_pkg::COORD_BITS] ? -diff_x : diff_x;
        mag_y = diff_y[pla_pkg::COORD_BITS] ? -diff_y : diff_y;
        // no open chain behaves like an explicit start
        restart = point.chain_start || !have_prev_reg;

        job.dx          = mag_x[pla_pkg::COORD_BITS-1:0];
        job.dy          = mag_y[pla_pkg::COORD_BITS-1:0];
        job.add_dist    = !restart;
        job.restart     = restart;
        job.chain_end   = point.chain_end;
        job.total_clear = point.total_clear;

        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        have_prev_next = have_prev_reg;
        if (job_push)
        begin
            prev_x_next    = point.point_x;
            prev_y_next    = point.point_y;
            have_prev_next = !point.chain_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            have_prev_reg <= have_prev_next;
        end
    end

endmodule

@@ hw/rtl/pla_fifo.sv @@
// ----------------------------------------------------------------------------
// pla_fifo
// short request queue between the front and the back
// ----------------------------------------------------------------------------
module pla_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pla_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          pop_valid,
    output pla_pkg::job_t pop_job
);

    pla_pkg::job_t entry_reg [pla_pkg::QUEUE_DEPTH];
    logic [pla_pkg::QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [pla_pkg::QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [pla_pkg::QCNT_BITS-1:0] count_reg, count_next;
    logic do_pop;

    assign full      = (count_reg == pla_pkg::QCNT_BITS'(pla_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_job   = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == pla_pkg::QPTR_BITS'(pla_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == pla_pkg::QPTR_BITS'(pla_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/pla_back.sv @@
// ----------------------------------------------------------------------------
// pla_back
// squares, bit-serial root, saturating chain and grand sums, result register
// ----------------------------------------------------------------------------
module pla_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    input  pla_pkg::job_t    job,
    output logic             job_pop,
    output logic             result_valid,
    input  logic             result_stall,
    output pla_pkg::result_t result
);

    pla_pkg::back_state_t state_reg, state_next;
    pla_pkg::job_t        job_reg, job_next;

    logic [pla_pkg::SQ_BITS-1:0]    sq_x_reg, sq_x_next;
    logic [pla_pkg::SQ_BITS-1:0]    sq_y_reg, sq_y_next;
    logic [pla_pkg::RAD_PAD-1:0]    rad_reg, rad_next;
    logic [pla_pkg::REM_BITS-1:0]   rem_reg, rem_next;
    logic [pla_pkg::ROOT_BITS-1:0]  root_reg, root_next;
    logic [pla_pkg::STEP_BITS-1:0]  step_reg, step_next;
    logic [pla_pkg::CHAIN_BITS-1:0] chain_reg, chain_next;
    logic [pla_pkg::TOTAL_BITS-1:0] grand_reg, grand_next;
    logic                           ovf_reg, ovf_next;
    logic                           out_valid_reg, out_valid_next;
    pla_pkg::result_t               out_reg, out_next;

    logic [pla_pkg::RAD_BITS-1:0]   rad_sum;
    logic [pla_pkg::REM_BITS+1:0]   rem_sh, trial, rem_sub;
    logic [pla_pkg::ROOT_BITS:0]    seg_len;
    logic [pla_pkg::CHAIN_BITS:0]   chain_sum;
    logic [pla_pkg::TOTAL_BITS:0]   grand_sum;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        sq_x_next      = sq_x_reg;
        sq_y_next      = sq_y_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        step_next      = step_reg;
        chain_next     = chain_reg;
        grand_next     = grand_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        job_pop        = 1'b0;

        rad_sum = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
        rem_sh  = {rem_reg, rad_reg[pla_pkg::RAD_PAD-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        rem_sub = rem_sh - trial;
        // round to nearest: bump when the remainder passes the root
        seg_len = {1'b0, root_reg}
                + {{pla_pkg::ROOT_BITS{1'b0}}, (rem_reg > {2'b00, root_reg})};
        chain_sum = {1'b0, chain_reg}
                  + {{(pla_pkg::CHAIN_BITS - pla_pkg::ROOT_BITS){1'b0}}, seg_len};
        grand_sum = {1'b0, grand_reg}
                  + {{(pla_pkg::TOTAL_BITS - pla_pkg::CHAIN_BITS + 1){1'b0}}, chain_reg};

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            pla_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop  = 1'b1;
                    job_next = job;
                    if (job.total_clear)
                    begin
                        grand_next = '0;
                        ovf_next   = 1'b0;
                    end
                    if (job.restart)
                    begin
                        chain_next = '0;
                    end
                    if (job.add_dist)
                    begin
                        state_next = pla_pkg::ST_MUL;
                    end
                    else if (job.chain_end)
                    begin
                        state_next = pla_pkg::ST_CLOSE;
                    end
                end
            end
            pla_pkg::ST_MUL:
            begin
                sq_x_next  = {{pla_pkg::COORD_BITS{1'b0}}, job_reg.dx}
                           * {{pla_pkg::COORD_BITS{1'b0}}, job_reg.dx};
                sq_y_next  = {{pla_pkg::COORD_BITS{1'b0}}, job_reg.dy}
                           * {{pla_pkg::COORD_BITS{1'b0}}, job_reg.dy};
                state_next = pla_pkg::ST_SUM;
            end
            pla_pkg::ST_SUM:
            begin
                rad_next   = {{(pla_pkg::RAD_PAD - pla_pkg::RAD_BITS){1'b0}}, rad_sum};
                rem_next   = '0;
                root_next  = '0;
                step_next  = pla_pkg::STEP_BITS'(pla_pkg::ROOT_STEPS - 1);
                state_next = pla_pkg::ST_ROOT;
            end
            pla_pkg::ST_ROOT:
            begin
                // one root bit per cycle, two radicand bits shifted in
                rad_next = {rad_reg[pla_pkg::RAD_PAD-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sub[pla_pkg::REM_BITS-1:0];
                    root_next = {root_reg[pla_pkg::ROOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh[pla_pkg::REM_BITS-1:0];
                    root_next = {root_reg[pla_pkg::ROOT_BITS-2:0], 1'b0};
                end
                if (step_reg == '0)
                begin
                    state_next = pla_pkg::ST_CHAIN;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            pla_pkg::ST_CHAIN:
            begin
                if (chain_sum[pla_pkg::CHAIN_BITS])
                begin
                    chain_next = '1;
                    ovf_next   = 1'b1;
                end
                else
                begin
                    chain_next = chain_sum[pla_pkg::CHAIN_BITS-1:0];
                end
                state_next = job_reg.chain_end ? pla_pkg::ST_CLOSE : pla_pkg::ST_IDLE;
            end
            pla_pkg::ST_CLOSE:
            begin
                if (!(out_valid_reg && result_stall))
                begin
                    out_next.chain_length = chain_reg;
                    if (grand_sum[pla_pkg::TOTAL_BITS])
                    begin
                        grand_next             = '1;
                        ovf_next               = 1'b1;
                        out_next.total_length  = '1;
                        out_next.saturated     = 1'b1;
                    end
                    else
                    begin
                        grand_next             = grand_sum[pla_pkg::TOTAL_BITS-1:0];
                        out_next.total_length  = grand_sum[pla_pkg::TOTAL_BITS-1:0];
                        out_next.saturated     = ovf_reg;
                    end
                    out_valid_next = 1'b1;
                    chain_next     = '0;
                    state_next     = pla_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pla_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        sq_x_reg <= sq_x_next;
        sq_y_reg <= sq_y_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pla_pkg::ST_IDLE;
            step_reg      <= '0;
            chain_reg     <= '0;
            grand_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            chain_reg     <= chain_next;
            grand_reg     <= grand_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/polyline_length_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// polyline_length_accumulator_unit
// Euclidean length of polylines with a saturating grand total
// ----------------------------------------------------------------------------
// point channel: point_valid / point_stall carry one point request with
//   signed x,y (8 fraction bits) and the chain_start, chain_end and
//   total_clear flags. points queue in a two-entry buffer behind the front.
// result channel: result_valid / result_stall; one result per point with
//   chain_end set, giving the chain length, the grand total and the sticky
//   saturation flag.
// back end steps: a point that adds a segment passes through a pop, a squaring
//   step, a sum step, the one-bit-per-cycle square root and a chain add, plus
//   a close step when it ends a chain. a point with no segment only pops, and
//   then closes if it ends a chain. the back end pops the next point only
//   when it is back in idle.
// reset: asynchronous, active low; clears the previous point, both sums,
//   the saturation flag and all queued work.
// stall: a held result blocks the back end at its next close; the queue
//   then fills and point_stall rises.
// ----------------------------------------------------------------------------
module polyline_length_accumulator_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             point_valid,
    output logic             point_stall,
    input  pla_pkg::point_t  point,
    output logic             result_valid,
    input  logic             result_stall,
    output pla_pkg::result_t result
);

    logic          push, full, pop, pop_valid;
    pla_pkg::job_t push_job, pop_job;

    pla_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .job_full    (full),
        .job_push    (push),
        .job         (push_job)
    );

    pla_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_job   (pop_job)
    );

    pla_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (pop_valid),
        .job          (pop_job),
        .job_pop      (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ hw/rtl/pla_checker.sv @@
// ----------------------------------------------------------------------------
// pla_checker
// port-level checks on the polyline length accumulator
// ----------------------------------------------------------------------------
`include "polyline_length_accumulator_unit_assert.svh"

module pla_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             point_stall,
    input logic             result_valid,
    input logic             result_stall,
    input pla_pkg::result_t result
);

    `PLA_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && result_stall, result_valid)
    `PLA_ASSERT_NEXT(a_result_stable, clk, rst_n, result_valid && result_stall, $stable(result))
    // the total always includes the chain it reports, or sits at its maximum
    `PLA_ASSERT_NOW(a_total_covers_chain, clk, rst_n, result_valid, {{(pla_pkg::TOTAL_BITS - pla_pkg::CHAIN_BITS){1'b0}}, result.chain_length} <= result.total_length)
    // a result needs a full point pass and the queue starts empty
    `PLA_ASSERT_NOW(a_quiet_after_reset, clk, rst_n, !$past(rst_n), !result_valid && !point_stall)

endmodule

bind polyline_length_accumulator_unit pla_checker u_pla_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_stall  (point_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

@@ verif/tb_polyline_length_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// tb_polyline_length_accumulator_unit
// self-checking bench for the polyline length accumulator: a short table of
// hand-picked points, then random polylines and noise. every accepted point
// runs through a local predictor; results are compared field by field in
// order. both channels idle at random.
// ----------------------------------------------------------------------------
module tb_polyline_length_accumulator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS = pla_pkg::COORD_BITS;
    localparam int CHAIN_BITS = pla_pkg::CHAIN_BITS;
    localparam int TOTAL_BITS = pla_pkg::TOTAL_BITS;

    localparam logic [CHAIN_BITS-1:0] CHAIN_MAX = '1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
    localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] COORD_MAX = ~COORD_MIN;
    localparam int LIMIT_CYCLES  = 6_000_000;
    localparam int RANDOM_POINTS = 1850;
    localparam int TAIL_CYCLES   = 64;

    typedef struct {
        pla_pkg::point_t  pt;
        bit               typed;
        pla_pkg::result_t want;
    } directed_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             point_valid = 1'b0;
    logic             point_stall;
    pla_pkg::point_t  point = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    pla_pkg::result_t result;

    // predictor state
    logic [COORD_BITS-1:0] prev_x;
    logic [COORD_BITS-1:0] prev_y;
    bit                    chain_open;
    logic [CHAIN_BITS-1:0] chain_acc;
    logic [TOTAL_BITS-1:0] total_acc;
    bit                    sat_flag;

    pla_pkg::result_t pending_results[$];
    pla_pkg::result_t expected_head;
    int      mismatches = 0;
    int      points_sent = 0;
    int      cycle_count = 0;
    int      burst_left = 0;
    int      stall_left = 0;
    int      free_left = 0;
    bit      steady = 1'b0;

    polyline_length_accumulator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point        (point),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] abs_delta(input logic [COORD_BITS-1:0] a,
                                              input logic [COORD_BITS-1:0] b);
        longint sa;
        longint sb;
        sa = longint'($signed(a));
        sb = longint'($signed(b));
        return (sa > sb) ? sa - sb : sb - sa;
    endfunction

    // nearest integer root of a^2 + b^2; the fraction can never be exactly one half
    function automatic logic [63:0] rounded_hypot(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] rad;
        logic [63:0] root;
        logic [63:0] trial;
        rad = a * a + b * b;
        root = '0;
        for (int k = 25; k >= 0; k--) begin
            trial = root | (64'd1 << k);
            if (trial * trial <= rad)
                root = trial;
        end
        if (rad - root * root > root)
            root = root + 64'd1;
        return root;
    endfunction

    function automatic bit predict_point(input pla_pkg::point_t p, output pla_pkg::result_t r);
        logic [63:0] seg;
        r = '0;
        if (p.total_clear) begin
            total_acc = '0;
            sat_flag = 1'b0;
        end
        if (p.chain_start || !chain_open) begin
            chain_acc = '0;
        end
        else begin
            seg = rounded_hypot(abs_delta(p.point_x, prev_x), abs_delta(p.point_y, prev_y));
            if (seg > CHAIN_MAX - chain_acc) begin
                chain_acc = CHAIN_MAX;
                sat_flag = 1'b1;
            end
            else begin
                chain_acc = chain_acc + seg[CHAIN_BITS-1:0];
            end
        end
        prev_x = p.point_x;
        prev_y = p.point_y;
        chain_open = 1'b1;
        if (!p.chain_end)
            return 1'b0;
        if (chain_acc > TOTAL_MAX - total_acc) begin
            total_acc = TOTAL_MAX;
            sat_flag = 1'b1;
        end
        else begin
            total_acc = total_acc + chain_acc;
        end
        r.chain_length = chain_acc;
        r.total_length = total_acc;
        r.saturated = sat_flag;
        chain_acc = '0;
        chain_open = 1'b0;
        return 1'b1;
    endfunction

    function automatic pla_pkg::point_t random_point();
        pla_pkg::point_t p;
        p.point_x = COORD_BITS'($urandom);
        p.point_y = COORD_BITS'($urandom);
        p.chain_start = 1'($urandom_range(0, 1));
        p.chain_end = 1'($urandom_range(0, 1));
        p.total_clear = 1'($urandom_range(0, 1));
        return p;
    endfunction

    function automatic directed_row_t row(input int x, input int y, input int s, input int e,
                                          input int c, input int typed = 0,
                                          input longint len = 0, input longint tot = 0,
                                          input int sat = 0);
        directed_row_t r;
        r.pt.point_x = x[COORD_BITS-1:0];
        r.pt.point_y = y[COORD_BITS-1:0];
        r.pt.chain_start = s[0];
        r.pt.chain_end = e[0];
        r.pt.total_clear = c[0];
        r.typed = typed[0];
        r.want.chain_length = len[CHAIN_BITS-1:0];
        r.want.total_length = tot[TOTAL_BITS-1:0];
        r.want.saturated = sat[0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= 50)
            $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    endtask

    // called at a falling edge; returns at a falling edge with nothing scheduled
    task automatic send_point(input pla_pkg::point_t p, input bit typed = 1'b0,
                              input pla_pkg::result_t want = '0);
        pla_pkg::result_t predicted;
        bit               has_result;
        point_valid <= 1'b1;
        point <= p;
        do @(posedge clk); while (point_stall);
        has_result = predict_point(p, predicted);
        if (has_result)
            pending_results.push_back(typed ? want : predicted);
        points_sent++;
        @(negedge clk);
        if (!steady && burst_left == 0) begin
            point_valid <= 1'b0;
            point <= random_point();
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6))
                @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic drain_results();
        point_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // well-formed chain walking in small, medium or full-range steps
    task automatic random_chain();
        int                    n;
        pla_pkg::point_t       p;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        n = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 10);
        cx = COORD_BITS'($urandom);
        cy = COORD_BITS'($urandom);
        for (int i = 0; i < n; i++) begin
            p.point_x = cx;
            p.point_y = cy;
            p.chain_start = (i == 0) ? ($urandom_range(0, 5) != 0) : 1'b0;
            p.chain_end = (i == n - 1);
            p.total_clear = ($urandom_range(0, 29) == 0);
            send_point(p);
            case ($urandom_range(0, 5))
                0, 1: begin
                    cx = cx + COORD_BITS'($urandom_range(0, 1023)) - COORD_BITS'(512);
                    cy = cy + COORD_BITS'($urandom_range(0, 1023)) - COORD_BITS'(512);
                end
                2: begin
                    cx = cx + COORD_BITS'($urandom_range(0, 131071)) - COORD_BITS'(65536);
                    cy = cy + COORD_BITS'($urandom_range(0, 131071)) - COORD_BITS'(65536);
                end
                3: begin
                    cx = COORD_BITS'($urandom);
                    cy = COORD_BITS'($urandom);
                end
                4: begin
                    cx = ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN;
                    cy = ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN;
                end
                default: ;
            endcase
        end
    endtask

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stall pattern
    always @(negedge clk) begin
        if (steady) begin
            stall_left = 0;
            free_left = 0;
            result_stall <= 1'b0;
        end
        else if (stall_left > 0) begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (free_left > 0) begin
            free_left--;
            result_stall <= 1'b0;
        end
        else begin
            case ($urandom_range(0, 3))
                0: free_left = $urandom_range(100, 400);
                1: begin
                    stall_left = $urandom_range(1, 3);
                    free_left = $urandom_range(0, 3);
                end
                default: begin
                    stall_left = $urandom_range(1, 40);
                    free_left = $urandom_range(0, 30);
                end
            endcase
            result_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(result.chain_length), 64'd0);
            end
            else begin
                expected_head = pending_results.pop_front();
                if (result.chain_length !== expected_head.chain_length)
                    report_mismatch("chain_length", 64'(result.chain_length),
                                    64'(expected_head.chain_length));
                if (result.total_length !== expected_head.total_length)
                    report_mismatch("total_length", 64'(result.total_length),
                                    64'(expected_head.total_length));
                if (result.saturated !== expected_head.saturated)
                    report_mismatch("saturated", 64'(result.saturated),
                                    64'(expected_head.saturated));
            end
        end
    end

    initial begin
        directed_row_t rows[$];
        int            random_goal;
        bit            pressure_done;

        prev_x = '0;
        prev_y = '0;
        chain_open = 1'b0;
        chain_acc = '0;
        total_acc = '0;
        sat_flag = 1'b0;
        pressure_done = 1'b0;

        // one-point chain right after reset
        rows.push_back(row(0, 0, 1, 1, 0, 1, 0, 0, 0));
        // no open chain and no start flag: still begins a chain
        rows.push_back(row(0, 0, 0, 0, 1));
        rows.push_back(row(768, 1024, 0, 1, 0, 1, 1280, 1280, 0));
        // full-range moves along each axis and along the diagonal
        rows.push_back(row(-8388608, 0, 1, 0, 0));
        rows.push_back(row(8388607, 0, 0, 1, 0, 1, 16777215, 16778495, 0));
        rows.push_back(row(0, 8388607, 1, 0, 1));
        rows.push_back(row(0, -8388608, 0, 1, 0, 1, 16777215, 16777215, 0));
        rows.push_back(row(-8388608, -8388608, 1, 0, 1));
        rows.push_back(row(8388607, 8388607, 0, 1, 0));
        // start inside an open chain drops it
        rows.push_back(row(0, 0, 1, 0, 1));
        rows.push_back(row(0, 256, 0, 0, 0));
        rows.push_back(row(100, 100, 1, 0, 0));
        rows.push_back(row(100, 612, 0, 1, 0, 1, 512, 512, 0));
        // short segments where rounding decides, clear in the middle of a chain
        rows.push_back(row(5, 5, 1, 0, 0));
        rows.push_back(row(6, 6, 0, 0, 0));
        rows.push_back(row(7, 8, 0, 0, 0));
        rows.push_back(row(9, 11, 0, 0, 1));
        rows.push_back(row(9, 11, 0, 1, 0));
        rows.push_back(row(-1, -1, 1, 1, 1, 1, 0, 0, 0));
        // alternating bit patterns
        rows.push_back(row(5592405, -5592406, 1, 0, 0));
        rows.push_back(row(-5592406, 5592405, 0, 1, 0));
        rows.push_back(row(-1, 1, 1, 0, 0));
        rows.push_back(row(1, -1, 1, 1, 0));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send_point(rows[i].pt, rows[i].typed, rows[i].want);
        drain_results();

        random_goal = points_sent + RANDOM_POINTS;
        while (points_sent < random_goal) begin
            if ($urandom_range(0, 24) == 0)
                steady = !steady;
            if (!pressure_done && points_sent > random_goal - RANDOM_POINTS / 2) begin
                drain_results();
                pressure_done = 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
                send_point(random_point());
            else
                random_chain();
        end
        steady = 1'b0;
        drain_results();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
